@@ design/lpca_pkg.sv @@
package lpca_pkg;

  // Input word: two tracks, intercepts Q15.16 cm, slopes Q7.24
  typedef struct packed {
    logic signed [31:0] first_x_intercept;
    logic signed [31:0] first_y_intercept;
    logic signed [31:0] first_x_slope;
    logic signed [31:0] first_y_slope;
    logic signed [31:0] second_x_intercept;
    logic signed [31:0] second_y_intercept;
    logic signed [31:0] second_x_slope;
    logic signed [31:0] second_y_slope;
  } in_t;

  // Result word
  typedef struct packed {
    logic signed [31:0] mean_z;
    logic               parallel_flag;
    logic               saturated_flag;
  } out_t;

  // Flags that ride alongside the divider
  typedef struct packed {
    logic par;
    logic neg;
    logic satp;
    logic satn;
  } side_t;

  localparam int OPW  = 67;          // A..E dot products
  localparam int PW   = 2 * OPW;     // products of two dot products
  localparam int DENW = 136;         // denominator and partial numerators
  localparam int SW   = 137;         // numerator sum
  localparam int MINW = 33;          // threshold as a signed operand
  localparam int RHSW = PW + MINW;   // threshold times A*C
  localparam int CMPW = 168;         // parallel test compare width
  localparam int RW   = 170;         // divider remainder width
  localparam int QW   = 32;          // quotient bits

  localparam logic [31:0]            MIN_DEN_RESET = 32'd4295;
  localparam logic signed [OPW-1:0]  ONE_Q48       = 67'sh1_0000_0000_0000;
  localparam logic signed [31:0]     Z_MAX         = 32'sh7FFF_FFFF;
  localparam logic signed [31:0]     Z_MIN         = 32'sh8000_0000;

endpackage

@@ design/line_pair_closest_approach_z.sv @@
// Closest approach of two straight tracks, reported as the mean z of the two
// closest points (Q15.16 cm, saturated, with a flag). One word pair enters per
// clock; throughput is one word per cycle as long as the output side does not
// stall. The core of the pipeline is the 32-stage restoring divider that forms
// the rounded quotient, one bit per stage, behind eleven stages of dot products,
// limb multipliers, differences and the parallel test. Pairs whose 1 - cos^2
// falls below min_denominator / 2^32 (or whose directions coincide) come out
// with parallel_flag set and mean_z 0. min_denominator resets to 4295 and is
// written through the cfg channel, which is always ready; write it only while
// no word is in flight.
module line_pair_closest_approach_z (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  lpca_pkg::in_t   in_word,
  output logic            out_valid,
  input  logic            out_stall,
  output lpca_pkg::out_t  out_word,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [31:0]     cfg_data
);
  import lpca_pkg::*;

  // Whole pipeline advances together; hold everything while the output
  // register is full and stalled.
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;
  assign cfg_ready = 1'b1;

  logic [31:0] min_denominator;
  always_ff @(posedge clk) begin
    if (rst) begin
      min_denominator <= MIN_DEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_denominator <= cfg_data;
    end
  end

  // Valid bits for stages 0 through 10
  logic [10:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[9:0], in_valid};
    end
  end

  // Stage 0: capture the input word
  in_t s0;
  always_ff @(posedge clk) begin
    if (en && in_valid) s0 <= in_word;
  end

  // Stage 1: intercept differences
  logic signed [31:0] tx0, ty0, tx1, ty1;
  logic signed [32:0] dx, dy;
  always_ff @(posedge clk) begin
    if (en) begin
      tx0 <= s0.first_x_slope;
      ty0 <= s0.first_y_slope;
      tx1 <= s0.second_x_slope;
      ty1 <= s0.second_y_slope;
      dx  <= 33'(s0.first_x_intercept) - 33'(s0.second_x_intercept);
      dy  <= 33'(s0.first_y_intercept) - 33'(s0.second_y_intercept);
    end
  end

  // Stage 2: slope products and slope times intercept difference products
  logic signed [63:0] pxx0, pyy0, pxx1, pyy1, pxx01, pyy01;
  logic signed [64:0] pxd0, pyd0, pxd1, pyd1;
  always_ff @(posedge clk) begin
    if (en) begin
      pxx0  <= 64'(tx0) * 64'(tx0);
      pyy0  <= 64'(ty0) * 64'(ty0);
      pxx1  <= 64'(tx1) * 64'(tx1);
      pyy1  <= 64'(ty1) * 64'(ty1);
      pxx01 <= 64'(tx0) * 64'(tx1);
      pyy01 <= 64'(ty0) * 64'(ty1);
      pxd0  <= 65'(tx0) * 65'(dx);
      pyd0  <= 65'(ty0) * 65'(dy);
      pxd1  <= 65'(tx1) * 65'(dx);
      pyd1  <= 65'(ty1) * 65'(dy);
    end
  end

  // Stage 3: dot products A = d0.d0, B = d0.d1, C = d1.d1, D = d0.w, E = d1.w
  logic signed [OPW-1:0] dot_a, dot_b, dot_c, dot_d, dot_e;
  always_ff @(posedge clk) begin
    if (en) begin
      dot_a <= OPW'(pxx0) + OPW'(pyy0) + ONE_Q48;
      dot_c <= OPW'(pxx1) + OPW'(pyy1) + ONE_Q48;
      dot_b <= OPW'(pxx01) + OPW'(pyy01) + ONE_Q48;
      dot_d <= OPW'(pxd0) + OPW'(pyd0);
      dot_e <= OPW'(pxd1) + OPW'(pyd1);
    end
  end

  // Stages 4-5: cross products
  logic signed [PW-1:0] ac5, bb5, be5, cd5, ae5, bd5;
  lpca_mul #(.WA(OPW), .WB(OPW)) u_mul_ac (.clk, .en, .a(dot_a), .b(dot_c), .p(ac5));
  lpca_mul #(.WA(OPW), .WB(OPW)) u_mul_bb (.clk, .en, .a(dot_b), .b(dot_b), .p(bb5));
  lpca_mul #(.WA(OPW), .WB(OPW)) u_mul_be (.clk, .en, .a(dot_b), .b(dot_e), .p(be5));
  lpca_mul #(.WA(OPW), .WB(OPW)) u_mul_cd (.clk, .en, .a(dot_c), .b(dot_d), .p(cd5));
  lpca_mul #(.WA(OPW), .WB(OPW)) u_mul_ae (.clk, .en, .a(dot_a), .b(dot_e), .p(ae5));
  lpca_mul #(.WA(OPW), .WB(OPW)) u_mul_bd (.clk, .en, .a(dot_b), .b(dot_d), .p(bd5));

  // Stage 6: denominator and the two closest-point numerators
  logic signed [DENW-1:0] den6, t0_6, t1_6;
  logic signed [PW-1:0]   ac6;
  always_ff @(posedge clk) begin
    if (en) begin
      den6 <= DENW'(ac5) - DENW'(bb5);
      t0_6 <= DENW'(be5) - DENW'(cd5);
      t1_6 <= DENW'(ae5) - DENW'(bd5);
      ac6  <= ac5;
    end
  end

  // Stages 7-8: threshold times A*C
  logic signed [MINW-1:0] min_op;
  logic signed [RHSW-1:0] rhs8;
  assign min_op = {1'b0, min_denominator};
  lpca_mul #(.WA(PW), .WB(MINW)) u_mul_rhs (.clk, .en, .a(ac6), .b(min_op), .p(rhs8));

  // Stage 7: numerator sum
  logic signed [SW-1:0]   s7;
  logic signed [DENW-1:0] den7;
  always_ff @(posedge clk) begin
    if (en) begin
      s7   <= SW'(t0_6) + SW'(t1_6);
      den7 <= den6;
    end
  end

  // Stage 8: sign and magnitude of the numerator
  logic                   neg8;
  logic [SW-1:0]          mag8;
  logic signed [DENW-1:0] den8;
  always_ff @(posedge clk) begin
    if (en) begin
      neg8 <= s7[SW-1];
      mag8 <= s7[SW-1] ? SW'(-s7) : SW'(s7);
      den8 <= den7;
    end
  end

  // Stage 9: parallel test, rounding numerator and divisor
  logic [CMPW-1:0] lhs8;
  logic            par9, neg9;
  logic [RW-1:0]   num9, dv9, dvm9;
  assign lhs8 = CMPW'(den8) << 32;
  always_ff @(posedge clk) begin
    if (en) begin
      par9 <= (den8 <= 0) || (lhs8 < CMPW'($unsigned(rhs8)));
      neg9 <= neg8;
      num9 <= (RW'(mag8) << 24) + RW'(den8);
      dv9  <= RW'(den8) << 1;
      dvm9 <= (RW'(den8) << 32) + (RW'(den8) << 1);
    end
  end

  // Stage 10: saturation checks against 2^31 and 2^31 + 1 times the divisor
  side_t         side10;
  logic [RW-1:0] num10, dv10;
  always_ff @(posedge clk) begin
    if (en) begin
      side10.par  <= par9;
      side10.neg  <= neg9;
      side10.satp <= num9 >= (dv9 << 31);
      side10.satn <= num9 >= dvm9;
      num10       <= num9;
      dv10        <= dv9;
    end
  end

  // Stages 11-42: quotient bits
  logic          div_valid;
  side_t         div_side;
  logic [QW-1:0] quo;
  lpca_divider u_div (
    .clk, .rst, .en,
    .in_valid (vld[10]),
    .in_side  (side10),
    .n        (num10),
    .d        (dv10),
    .out_valid(div_valid),
    .out_side (div_side),
    .q        (quo)
  );

  // Output register: apply sign, saturation, parallel override
  out_t out_next;
  always_comb begin
    out_next.mean_z         = $signed(quo);
    out_next.parallel_flag  = 1'b0;
    out_next.saturated_flag = 1'b0;
    if (div_side.par) begin
      out_next.mean_z        = '0;
      out_next.parallel_flag = 1'b1;
    end else if (div_side.neg) begin
      if (div_side.satn) begin
        out_next.mean_z         = Z_MIN;
        out_next.saturated_flag = 1'b1;
      end else begin
        out_next.mean_z = $signed(-quo);
      end
    end else if (div_side.satp) begin
      out_next.mean_z         = Z_MAX;
      out_next.saturated_flag = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && div_valid) out_word <= out_next;
  end

endmodule

@@ design/lpca_mul.sv @@
module lpca_mul #(
  parameter int WA = 67,
  parameter int WB = 67
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [WA-1:0]  a,
  input  logic signed [WB-1:0]  b,
  output logic signed [WA+WB-1:0] p
);
  // Two-stage signed multiplier: 33x33 limb products, then a shifted sum.
  localparam int LA = (WA + 31) / 32;
  localparam int LB = (WB + 31) / 32;
  localparam int WP = WA + WB;

  logic signed [LA*32-1:0] a_ext;
  logic signed [LB*32-1:0] b_ext;
  logic signed [32:0]      la [LA];
  logic signed [32:0]      lb [LB];
  logic signed [65:0]      prod [LA*LB];
  logic signed [WP-1:0]    acc;

  assign a_ext = (LA*32)'(a);
  assign b_ext = (LB*32)'(b);

  always_comb begin
    for (int i = 0; i < LA; i++) begin
      if (i == LA - 1) la[i] = {a_ext[32*i+31], a_ext[32*i+:32]};
      else             la[i] = {1'b0, a_ext[32*i+:32]};
    end
    for (int j = 0; j < LB; j++) begin
      if (j == LB - 1) lb[j] = {b_ext[32*j+31], b_ext[32*j+:32]};
      else             lb[j] = {1'b0, b_ext[32*j+:32]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LA; i++) begin
        for (int j = 0; j < LB; j++) begin
          prod[i*LB+j] <= 66'(la[i]) * 66'(lb[j]);
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < LA; i++) begin
      for (int j = 0; j < LB; j++) begin
        acc = acc + (WP'(prod[i*LB+j]) <<< (32 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) p <= acc;
  end

endmodule

@@ design/lpca_divider.sv @@
module lpca_divider (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  lpca_pkg::side_t       in_side,
  input  logic [lpca_pkg::RW-1:0] n,
  input  logic [lpca_pkg::RW-1:0] d,
  output logic                  out_valid,
  output lpca_pkg::side_t       out_side,
  output logic [lpca_pkg::QW-1:0] q
);
  import lpca_pkg::*;

  // One quotient bit per stage, most significant first.
  logic [RW-1:0] rem  [QW];
  logic [RW-1:0] dd   [QW];
  logic [QW-1:0] qq   [QW];
  side_t         sd   [QW];
  logic [QW-1:0] vl;

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int SH = QW - 1 - j;
    logic [RW-1:0] src_rem;
    logic [RW-1:0] src_d;
    logic [QW-1:0] src_q;
    side_t         src_side;
    logic          src_valid;
    logic [RW:0]   trial;

    if (j == 0) begin : g_first
      assign src_rem   = n;
      assign src_d     = d;
      assign src_q     = '0;
      assign src_side  = in_side;
      assign src_valid = in_valid;
    end else begin : g_next
      assign src_rem   = rem[j-1];
      assign src_d     = dd[j-1];
      assign src_q     = qq[j-1];
      assign src_side  = sd[j-1];
      assign src_valid = vl[j-1];
    end

    assign trial = {1'b0, src_rem} - {1'b0, src_d << SH};

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[j] <= 1'b0;
      end else if (en) begin
        vl[j] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dd[j] <= src_d;
        sd[j] <= src_side;
        if (!trial[RW]) begin
          rem[j] <= trial[RW-1:0];
          qq[j]  <= src_q | (QW'(1) << SH);
        end else begin
          rem[j] <= src_rem;
          qq[j]  <= src_q;
        end
      end
    end
  end

  assign out_valid = vl[QW-1];
  assign out_side  = sd[QW-1];
  assign q         = qq[QW-1];

endmodule

@@ design/lpca_checker.sv @@
module lpca_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input lpca_pkg::out_t out_word
);
  import lpca_pkg::*;

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  // Input backpressure only while the output is blocked
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  // Parallel pairs carry zero z and no saturation
  a_parallel: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.parallel_flag |->
      out_word.mean_z == 0 && !out_word.saturated_flag)
    else $error("parallel result not zeroed");

  // Saturated z sits at a rail
  a_saturated: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.saturated_flag |->
      out_word.mean_z == Z_MAX || out_word.mean_z == Z_MIN)
    else $error("saturated result off the rail");

endmodule

bind line_pair_closest_approach_z lpca_checker u_lpca_checker (.*);
